@@ hdl/lpmc_pkg.sv @@
`default_nettype none
package lpmc_pkg;

    localparam int MODE_W  = 3;
    localparam int CNT_W   = 16;
    localparam int RAMP_W  = 8;
    localparam int LEVEL_W = 15;

    localparam logic [MODE_W-1:0] MODE_OFF     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ON      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BLINK   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CHASE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DIM     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DIM_ALT = 3'd5;

    localparam logic [1:0] CFG_HOLDOFF  = 2'd0;
    localparam logic [1:0] CFG_LOOP     = 2'd1;
    localparam logic [1:0] CFG_DIM_STEP = 2'd2;

    localparam logic [CNT_W-1:0]   HOLDOFF_RST  = 16'd1000;
    localparam logic [CNT_W-1:0]   LOOP_RST     = 16'd500;
    localparam logic [RAMP_W-1:0]  DIM_STEP_RST = 8'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 15'd19999;

    typedef struct packed {
        logic enable;   // a word is taken this cycle
        logic step;     // iteration start in a dimmer mode
        logic clear;    // iteration start in the off mode, the mode that follows the dimmers
        logic alt;      // alternating dimmer: even LEDs take the complement
    } t_dim_ctrl;

endpackage
`default_nettype wire

@@ hdl/lpmc_dimmer.sv @@
`default_nettype none
module lpmc_dimmer
    import lpmc_pkg::*;
#(
    parameter int RAMP_TOP       = 200,
    parameter int LEVEL_PER_STEP = 100
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dim_ctrl          i_ctrl,
    output logic [LEVEL_W-1:0]      o_level_odd,
    output logic [LEVEL_W-1:0]      o_level_even
);

    localparam int PROD_W = RAMP_W + $clog2(LEVEL_PER_STEP + 1);
    // cap compare runs wide enough for both the product and the cap value
    localparam int CMP_W  = (PROD_W > LEVEL_W) ? PROD_W : LEVEL_W;
    localparam logic [RAMP_W-1:0] TOP = RAMP_W'(RAMP_TOP);

    logic [RAMP_W-1:0]  r_ramp, n_ramp;
    logic               r_rising, n_rising;
    logic [LEVEL_W-1:0] r_held_odd, n_held_odd;
    logic [LEVEL_W-1:0] r_held_even, n_held_even;
    logic [RAMP_W-1:0]  w_rest;
    logic [PROD_W-1:0]  w_prod_odd, w_prod_even;

    function automatic logic [LEVEL_W-1:0] f_cap(input logic [PROD_W-1:0] p);
        logic [LEVEL_W-1:0] v;
        if (CMP_W'(p) > CMP_W'(LEVEL_MAX)) begin
            v = LEVEL_MAX;
        end else begin
            v = LEVEL_W'(p);
        end
        return v;
    endfunction

    always_comb begin
        n_ramp   = r_ramp;
        n_rising = r_rising;
        if (i_ctrl.step) begin
            if (r_rising) begin
                if (r_ramp < TOP) n_ramp = r_ramp + 1'b1;
                if (n_ramp >= TOP) n_rising = 1'b0;
            end else begin
                if (r_ramp != '0) n_ramp = r_ramp - 1'b1;
                if (n_ramp == '0) n_rising = 1'b1;
            end
        end else if (i_ctrl.clear) begin
            n_ramp   = '0;
            n_rising = 1'b1;
        end
    end

    assign w_rest      = (n_ramp >= TOP) ? '0 : TOP - n_ramp;
    assign w_prod_odd  = PROD_W'(n_ramp) * PROD_W'(LEVEL_PER_STEP);
    assign w_prod_even = PROD_W'(w_rest) * PROD_W'(LEVEL_PER_STEP);

    always_comb begin
        n_held_odd  = r_held_odd;
        n_held_even = r_held_even;
        if (i_ctrl.step) begin
            n_held_odd  = f_cap(w_prod_odd);
            n_held_even = i_ctrl.alt ? f_cap(w_prod_even) : f_cap(w_prod_odd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp      <= '0;
            r_rising    <= 1'b1;
            r_held_odd  <= '0;
            r_held_even <= '0;
        end else if (i_ctrl.enable) begin
            r_ramp      <= n_ramp;
            r_rising    <= n_rising;
            r_held_odd  <= n_held_odd;
            r_held_even <= n_held_even;
        end
    end

    // levels in force for the word being taken
    assign o_level_odd  = n_held_odd;
    assign o_level_even = n_held_even;

endmodule
`default_nettype wire

@@ hdl/led_pattern_mode_controller.sv @@
`default_nettype none
// An accepted tick word's result word is in the output register from the cycle after it is taken.
// Throughput: one tick word per cycle while the output side takes words; all state updates
// are counters and compares settled between the tick handshake and the output register.
// Reset (synchronous, active low): mode off, counters and ramp zero, registers back to
// holdoff 1000, loop period 500, dimmer step 2; output register empty.
module led_pattern_mode_controller
    import lpmc_pkg::*;
#(
    parameter int LED_COUNT      = 5,
    parameter int RAMP_TOP       = 200,
    parameter int LEVEL_PER_STEP = 100
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration writes
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [CNT_W-1:0]   i_cfg_data,
    // tick words
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_button_press,
    // result words
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [MODE_W-1:0]       o_mode_now,
    output logic [4:0]              o_led_mask,
    output logic                    o_pwm_active,
    output logic [LEVEL_W-1:0]      o_level_odd,
    output logic [LEVEL_W-1:0]      o_level_even
);

    localparam int SLOT_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    // configuration
    logic [CNT_W-1:0]  r_holdoff;
    logic [CNT_W-1:0]  r_loop;
    logic [RAMP_W-1:0] r_dim_step;

    // sequencing state
    logic [MODE_W-1:0] r_mode, n_mode;
    logic              r_press, n_press;
    logic [CNT_W-1:0]  r_since, n_since;
    logic [CNT_W-1:0]  r_phase, n_phase;
    logic [SLOT_W-1:0] r_slot, n_slot;

    // output register
    logic              r_out_valid;
    logic [MODE_W-1:0] r_mode_out;
    logic [4:0]        r_mask_out;
    logic              r_pwm_out;
    logic [LEVEL_W-1:0] r_lvl_odd_out, r_lvl_even_out;

    logic              w_take;
    logic              w_start;
    logic              w_pending;
    logic              w_advance;
    logic              w_dim_now;
    logic [CNT_W-2:0]  w_half;
    logic [CNT_W-3:0]  w_quarter;
    logic [CNT_W-1:0]  w_len;
    logic [CNT_W:0]    w_phase_inc;
    logic [SLOT_W:0]   w_slot_inc;
    logic [LED_COUNT-1:0]   w_mask;
    logic [LED_COUNT+4:0]   w_mask_ext;
    logic              w_pwm;
    logic [LEVEL_W-1:0] w_lvl_odd, w_lvl_even;
    t_dim_ctrl         w_dim_ctrl;

    // the output register frees as it is read, so a word can enter every cycle while it is read
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_take     = i_in_valid && o_in_ready;

    // iteration lengths; a length that comes out zero counts as one tick
    assign w_half    = (r_loop[CNT_W-1:1] == '0) ? (CNT_W-1)'(1) : r_loop[CNT_W-1:1];
    assign w_quarter = (r_loop[CNT_W-1:2] == '0) ? (CNT_W-2)'(1) : r_loop[CNT_W-1:2];

    // a press on any tick is latched; it is looked at only on an iteration's first tick
    assign w_pending = r_press || i_button_press;
    assign w_start   = (r_phase == '0) && (r_slot == '0);
    assign w_advance = w_start && w_pending && (r_since >= r_holdoff);

    always_comb begin
        n_mode = r_mode;
        if (w_advance) begin
            n_mode = (r_mode == MODE_DIM_ALT) ? MODE_OFF : r_mode + 1'b1;
        end
    end

    assign n_press   = w_start ? 1'b0 : w_pending;
    assign w_dim_now = (n_mode == MODE_DIM) || (n_mode == MODE_DIM_ALT);

    // The previous mode always trails the mode by one, so "previous was a dimmer
    // while this one is not" reduces to the off mode (previous = alternating dimmer).
    assign w_dim_ctrl.enable = w_take;
    assign w_dim_ctrl.step   = w_start && w_dim_now;
    assign w_dim_ctrl.clear  = w_start && (n_mode == MODE_OFF);
    assign w_dim_ctrl.alt    = (n_mode == MODE_DIM_ALT);

    lpmc_dimmer #(
        .RAMP_TOP       (RAMP_TOP),
        .LEVEL_PER_STEP (LEVEL_PER_STEP)
    ) u_dimmer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_dim_ctrl),
        .o_level_odd  (w_lvl_odd),
        .o_level_even (w_lvl_even)
    );

    // LED pattern for this tick, from the mode in force after the iteration start
    always_comb begin
        w_mask = '0;
        w_pwm  = 1'b0;
        case (n_mode)
            MODE_ON:      w_mask = '1;
            MODE_BLINK:   w_mask = ({1'b0, r_phase} < {2'b0, w_half}) ? '1 : '0;
            MODE_CHASE:   w_mask = LED_COUNT'(1) << r_slot;
            MODE_DIM:     w_pwm  = 1'b1;
            MODE_DIM_ALT: w_pwm  = 1'b1;
            default:      w_mask = '0;
        endcase
    end

    // LEDs above the fifth are dropped by the field width
    assign w_mask_ext = {5'b0, w_mask};

    // phase and chase slot counters
    assign w_phase_inc = {1'b0, r_phase} + 1'b1;
    assign w_slot_inc  = {1'b0, r_slot} + 1'b1;

    always_comb begin
        case (n_mode)
            MODE_BLINK:   w_len = {w_half, 1'b0};
            MODE_DIM:     w_len = (r_dim_step == '0) ? CNT_W'(1) : CNT_W'(r_dim_step);
            MODE_DIM_ALT: w_len = (r_dim_step == '0) ? CNT_W'(1) : CNT_W'(r_dim_step);
            default:      w_len = (r_loop == '0) ? CNT_W'(1) : r_loop;
        endcase
    end

    always_comb begin
        n_phase = w_phase_inc[CNT_W-1:0];
        n_slot  = '0;
        if (n_mode == MODE_CHASE) begin
            n_slot = r_slot;
            if (w_phase_inc >= {3'b0, w_quarter}) begin
                n_phase = '0;
                n_slot  = (w_slot_inc >= (SLOT_W+1)'(LED_COUNT)) ? '0 : w_slot_inc[SLOT_W-1:0];
            end
        end else if (w_phase_inc >= {1'b0, w_len}) begin
            n_phase = '0;
        end
    end

    // ticks since the last accepted press, saturating; the compare above uses the old count
    always_comb begin
        if (w_advance) begin
            n_since = CNT_W'(1);
        end else if (r_since != '1) begin
            n_since = r_since + 1'b1;
        end else begin
            n_since = r_since;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holdoff  <= HOLDOFF_RST;
            r_loop     <= LOOP_RST;
            r_dim_step <= DIM_STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HOLDOFF:  r_holdoff  <= i_cfg_data;
                CFG_LOOP:     r_loop     <= i_cfg_data;
                CFG_DIM_STEP: r_dim_step <= i_cfg_data[RAMP_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_OFF;
            r_press <= 1'b0;
            r_since <= '0;
            r_phase <= '0;
            r_slot  <= '0;
        end else if (w_take) begin
            r_mode  <= n_mode;
            r_press <= n_press;
            r_since <= n_since;
            r_phase <= n_phase;
            r_slot  <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result word payload; dimmer levels only show while PWM drives the LEDs
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_mode_out     <= n_mode;
            r_mask_out     <= w_mask_ext[4:0];
            r_pwm_out      <= w_pwm;
            r_lvl_odd_out  <= w_pwm ? w_lvl_odd  : '0;
            r_lvl_even_out <= w_pwm ? w_lvl_even : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_mode_now   = r_mode_out;
    assign o_led_mask   = r_mask_out;
    assign o_pwm_active = r_pwm_out;
    assign o_level_odd  = r_lvl_odd_out;
    assign o_level_even = r_lvl_even_out;

endmodule
`default_nettype wire
